// ===== src/kvss_pkg.sv =====
package kvss_pkg;

    localparam int SLOTS      = 16;
    localparam int MAX_KEYS   = 64;
    localparam int MAX_LENGTH = 8;

    localparam int CMD_W  = 2;
    localparam int KEY_W  = 6;
    localparam int POS_W  = 3;
    localparam int WORD_W = 64;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 4;
    localparam int CNT_W  = 5;
    localparam int LEN_W  = 4;

    localparam int IN_BITS  = CMD_W + KEY_W + POS_W + WORD_W;
    localparam int OUT_BITS = STAT_W + SLOT_W + WORD_W + CNT_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam int VEC_DEPTH = SLOTS * MAX_LENGTH;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_PRESENT = 2'd3
    } t_status;

endpackage

// ===== src/kvss_ram.sv =====
module kvss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/keyed_vector_slot_store_core.sv =====
// Keyed vector slot store.
// Requests arrive on the s_axis channel: tdata holds command, key, element
// position and a 64-bit word. An insert at position 0 claims the lowest free
// slot for the key; later positions write words of that slot. Remove frees the
// key's slot, read returns one word. Each request yields exactly one response
// on m_axis: status, slot, read word and the number of vectors held.
// The vector length register is written through i_cfg_wen / i_cfg_wdata; the
// user must do so only while the block is idle, which the block does not
// enforce. Values outside 1..8 are clamped. One request is processed at a
// time: accept, then a lookup state that reads the key map RAM and runs the
// free-slot priority encoder, then a push state that waits for the vector RAM
// read and loads the response register. A new request is accepted only after
// the previous one has left the push state.
// The response register decouples the output: a new request is accepted while
// a response waits; if the receiver stalls, the next response waits in the
// sequencer until the register frees up.
// Reset (synchronous, active low) empties both maps, clears the count and
// restores a vector length of 8. Vector words are not cleared.
module keyed_vector_slot_store_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wen,
    input  logic [kvss_pkg::LEN_W-1:0]     i_cfg_wdata,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // command[1:0], key[7:2], element_pos[10:8], element_word[74:11], zero pad
    input  logic [kvss_pkg::IN_W-1:0]      i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // status[1:0], slot[5:2], read_word[69:6], stored_count[74:70], zero pad
    output logic [kvss_pkg::OUT_W-1:0]     o_m_axis_tdata
);

    localparam int SW = kvss_pkg::SLOT_W;
    localparam int PW = kvss_pkg::POS_W;
    localparam int KW = kvss_pkg::KEY_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [kvss_pkg::LEN_W-1:0]  r_len;
    logic [kvss_pkg::CMD_W-1:0]  r_cmd;
    logic [KW-1:0]               r_key;
    logic [PW-1:0]               r_pos;
    logic [kvss_pkg::WORD_W-1:0] r_word;
    logic [kvss_pkg::MAX_KEYS-1:0] r_kvalid;
    logic [kvss_pkg::SLOTS-1:0]  r_busy;
    logic [kvss_pkg::CNT_W-1:0]  r_count;

    logic [kvss_pkg::STAT_W-1:0] r_res_status;
    logic [SW-1:0]               r_res_slot;
    logic                        r_res_hit;

    logic                        r_out_valid;
    logic [kvss_pkg::OUT_W-1:0]  r_out_data;

    logic                        accept;
    logic [KW-1:0]               map_raddr;
    logic [SW-1:0]               map_rdata;
    logic                        map_we;
    logic                        vec_we;
    logic [SW+PW-1:0]            vec_waddr;
    logic [kvss_pkg::WORD_W-1:0] vec_rdata;

    logic                        present;
    logic                        full;
    logic [SW-1:0]               free_slot;
    logic [kvss_pkg::LEN_W-1:0]  len_use;
    logic                        pos_ok;
    logic                        is_claim;
    logic                        is_remove;
    logic                        out_free;

    logic [kvss_pkg::STAT_W-1:0] n_status;
    logic [SW-1:0]               n_slot;
    logic                        n_hit;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    assign map_raddr = accept ? i_s_axis_tdata[KW+1:2] : r_key;

    kvss_ram #(
        .WIDTH(SW),
        .DEPTH(kvss_pkg::MAX_KEYS)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (map_we),
        .i_waddr(r_key),
        .i_wdata(free_slot),
        .i_raddr(map_raddr),
        .o_rdata(map_rdata)
    );

    kvss_ram #(
        .WIDTH(kvss_pkg::WORD_W),
        .DEPTH(kvss_pkg::VEC_DEPTH)
    ) u_vec (
        .i_clk  (i_clk),
        .i_we   (vec_we),
        .i_waddr(vec_waddr),
        .i_wdata(r_word),
        .i_raddr({map_rdata, r_pos}),
        .o_rdata(vec_rdata)
    );

    always_comb begin
        free_slot = '0;
        for (int s = kvss_pkg::SLOTS - 1; s >= 0; s--) begin
            if (!r_busy[s]) begin
                free_slot = SW'(s);
            end
        end
    end

    assign full    = &r_busy;
    assign present = r_kvalid[r_key];

    always_comb begin
        if (r_len == '0) begin
            len_use = kvss_pkg::LEN_W'(1);
        end else if (r_len > kvss_pkg::LEN_W'(kvss_pkg::MAX_LENGTH)) begin
            len_use = kvss_pkg::LEN_W'(kvss_pkg::MAX_LENGTH);
        end else begin
            len_use = r_len;
        end
    end

    assign pos_ok = kvss_pkg::LEN_W'(r_pos) < len_use;

    always_comb begin
        n_status  = kvss_pkg::ST_OK;
        n_slot    = '0;
        n_hit     = 1'b0;
        is_claim  = 1'b0;
        is_remove = 1'b0;
        vec_we    = 1'b0;
        vec_waddr = {map_rdata, r_pos};
        if (r_cmd == kvss_pkg::CMD_INSERT && r_pos == '0) begin
            if (present) begin
                n_status = kvss_pkg::ST_PRESENT;
                n_slot   = map_rdata;
            end else if (full) begin
                n_status = kvss_pkg::ST_FULL;
            end else begin
                is_claim  = 1'b1;
                n_slot    = free_slot;
                vec_we    = 1'b1;
                vec_waddr = {free_slot, PW'(0)};
            end
        end else if (r_cmd != kvss_pkg::CMD_NONE) begin
            if (!present) begin
                n_status = kvss_pkg::ST_ABSENT;
            end else begin
                n_slot = map_rdata;
                if (r_cmd == kvss_pkg::CMD_REMOVE) begin
                    is_remove = 1'b1;
                end else if (pos_ok) begin
                    if (r_cmd == kvss_pkg::CMD_INSERT) begin
                        vec_we = 1'b1;
                    end else begin
                        n_hit = 1'b1;
                    end
                end
            end
        end
        if (r_state != S_LOOK) begin
            is_claim  = 1'b0;
            is_remove = 1'b0;
            vec_we    = 1'b0;
        end
    end

    assign map_we = is_claim;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= kvss_pkg::LEN_RESET;
            r_kvalid    <= '0;
            r_busy      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wen) begin
                r_len <= i_cfg_wdata;
            end
            if (is_claim) begin
                r_kvalid[r_key]     <= 1'b1;
                r_busy[free_slot]   <= 1'b1;
                r_count             <= r_count + kvss_pkg::CNT_W'(1);
            end else if (is_remove) begin
                r_kvalid[r_key]     <= 1'b0;
                r_busy[map_rdata]   <= 1'b0;
                if (r_count != '0) begin
                    r_count <= r_count - kvss_pkg::CNT_W'(1);
                end
            end
            if (r_state == S_PUSH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_s_axis_tdata[1:0];
            r_key  <= i_s_axis_tdata[KW+1:2];
            r_pos  <= i_s_axis_tdata[KW+PW+1:KW+2];
            r_word <= i_s_axis_tdata[kvss_pkg::IN_BITS-1:KW+PW+2];
        end
        if (r_state == S_LOOK) begin
            r_res_status <= n_status;
            r_res_slot   <= n_slot;
            r_res_hit    <= n_hit;
        end
        if (r_state == S_PUSH && out_free) begin
            r_out_data <= {
                (kvss_pkg::OUT_W - kvss_pkg::OUT_BITS)'(0),
                r_count,
                r_res_hit ? vec_rdata : kvss_pkg::WORD_W'(0),
                r_res_slot,
                r_res_status
            };
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== src/kvss_checker.sv =====
module kvss_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_axis_tvalid,
    input logic                       o_s_axis_tready,
    input logic                       o_m_axis_tvalid,
    input logic                       i_m_axis_tready,
    input logic [kvss_pkg::OUT_W-1:0] o_m_axis_tdata
);

    logic [kvss_pkg::STAT_W-1:0] rsp_status;
    logic [kvss_pkg::WORD_W-1:0] rsp_word;
    logic [kvss_pkg::CNT_W-1:0]  rsp_count;

    assign rsp_status = o_m_axis_tdata[1:0];
    assign rsp_word   = o_m_axis_tdata[69:6];
    assign rsp_count  = o_m_axis_tdata[74:70];

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request accepted while previous one in flight");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> rsp_count <= kvss_pkg::CNT_W'(kvss_pkg::SLOTS))
        else $error("stored count above slot total");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && rsp_status == kvss_pkg::ST_FULL
        |-> rsp_count == kvss_pkg::CNT_W'(kvss_pkg::SLOTS))
        else $error("table full reported with free slots");

    a_err_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && rsp_status != kvss_pkg::ST_OK |-> rsp_word == '0)
        else $error("nonzero read word on failed request");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
        |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled response changed");

endmodule

bind keyed_vector_slot_store_core kvss_checker u_kvss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata)
);
